// File: hdl/strip_hit_clusterizer_assert.svh
// Assertion helpers shared by the clusterizer modules.
// Each expects clk_i and rst_ni in the scope where it is used.
`ifndef STRIP_HIT_CLUSTERIZER_ASSERT_SVH
`define STRIP_HIT_CLUSTERIZER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define SHC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SHC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SHC_ASSERT_IMP(lbl, ante, cons, msg)
`define SHC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// File: hdl/shc_pkg.sv
package shc_pkg;

  // Field widths of the input word
  localparam int unsigned STRIP_IN_W = 10;
  localparam int unsigned CHARGE_W   = 10;
  localparam int unsigned TIME_W     = 8;

  // Field widths of the cluster word
  localparam int unsigned SIZE_W  = 6;
  localparam int unsigned SUM_W   = 16;
  localparam int unsigned POS_W   = 18;
  localparam int unsigned CTIME_W = 16;

  // Fixed point fraction of position and time
  localparam int unsigned FRAC_BITS = 8;

  // Saturation limits
  localparam int unsigned SIZE_SAT   = 63;
  localparam int unsigned POS_SAT    = 262143;
  localparam int unsigned CTIME_SAT  = 65535;

  // Divider step counter, covers up to 31 quotient bits
  localparam int unsigned DIV_STEP_W = 5;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_POS_GO,
    ST_POS_WAIT,
    ST_TIM_GO,
    ST_TIM_WAIT,
    ST_PUSH,
    ST_UPDATE
  } shc_state_e;

  // Divider start request
  typedef struct packed {
    logic                  start;
    logic [DIV_STEP_W-1:0] steps;
    logic [SUM_W-1:0]      divisor;
    logic [SUM_W-1:0]      rem_init;
  } shc_div_req_t;

endpackage

// File: hdl/shc_if.sv
// Strip hit word channel
interface shc_hit_if import shc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STRIP_IN_W-1:0] strip_number;
  logic [CHARGE_W-1:0]   strip_charge;
  logic [TIME_W-1:0]     strip_time;
  logic                  last_strip;

  modport source (output valid, strip_number, strip_charge, strip_time, last_strip,
                  input ready);
  modport sink   (input valid, strip_number, strip_charge, strip_time, last_strip,
                  output ready);
endinterface

// Cluster word channel
interface shc_cluster_if import shc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SIZE_W-1:0]  cluster_size;
  logic [SUM_W-1:0]   cluster_charge;
  logic [POS_W-1:0]   cluster_position;
  logic [CTIME_W-1:0] cluster_time;
  logic               oversize;
  logic               last_of_board;

  modport source (output valid, cluster_size, cluster_charge, cluster_position,
                  cluster_time, oversize, last_of_board, input ready);
  modport sink   (input valid, cluster_size, cluster_charge, cluster_position,
                  cluster_time, oversize, last_of_board, output ready);
endinterface

// Threshold write channel
interface shc_cfg_if import shc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CHARGE_W-1:0] charge_threshold;

  modport source (output valid, charge_threshold, input ready);
  modport sink   (input valid, charge_threshold, output ready);
endinterface

// File: hdl/shc_div.sv
`include "strip_hit_clusterizer_assert.svh"

// Restoring divider, one quotient bit per cycle.
// The numerator arrives split: rem_init holds its upper part (already below the
// divisor), num_i holds the remaining bits left aligned. When done_o pulses the
// quotient sits in the low bits of quot_o, the bits above are zero.
module shc_div import shc_pkg::*; #(
  parameter int unsigned QuotW = 18
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  shc_div_req_t     req_i,
  input  logic [QuotW-1:0] num_i,
  output logic             done_o,
  output logic [QuotW-1:0] quot_o
);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIV_STEP_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0]      rem_q, rem_d;
  logic [SUM_W-1:0]      dvs_q, dvs_d;
  logic [QuotW-1:0]      sh_q, sh_d;

  logic [SUM_W:0] trial;
  logic [SUM_W:0] diff;
  logic           ge;

  // Trial subtract
  assign trial = {rem_q, sh_q[QuotW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  // Step control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    sh_d   = sh_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = req_i.rem_init;
      dvs_d  = req_i.divisor;
      sh_d   = num_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      sh_d  = {sh_q[QuotW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath, no reset
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    sh_q  <= sh_d;
  end

  assign done_o = done_q;
  assign quot_o = sh_q;

  `SHC_ASSERT_IMP(a_rem_below_divisor, busy_q, rem_q < dvs_q, "divider remainder overflow")

endmodule

// File: hdl/strip_hit_clusterizer.sv
// Strip hit clusterizer.
// hit_i takes one strip hit word per handshake (strip number, charge, time, end-of-list
// mark), strips of one board in ascending order. cfg_i writes the charge threshold; it
// is always ready; the user must write it only while the block is idle, which the
// block itself does not enforce. cluster_o delivers one word per closed cluster: size,
// charge sum, charge-weighted position and time (8 fraction bits), oversize flag and
// last-of-board mark. An item is taken only in the idle state. One shared restoring
// divider produces the position quotient (STRIP_BITS + 8 bits) and then the time
// quotient (16 bits) of each closed cluster, one bit per cycle. A counting hit that
// closes a cluster and also ends the list produces two words.
// The cluster word sits in an output register; the next item is accepted while it waits.
// If the receiver stalls, the block holds in its push step until the register frees up.
// Reset clears the threshold to 0, drops any open cluster and empties the output register.
module strip_hit_clusterizer import shc_pkg::*; #(
  parameter int unsigned MAX_CLUSTER = 32,
  parameter int unsigned STRIP_BITS  = 10
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  shc_hit_if.sink       hit_i,
  shc_cluster_if.source cluster_o,
  shc_cfg_if.sink       cfg_i
);

  localparam int unsigned CNT_W     = $clog2(MAX_CLUSTER + 1);
  localparam int unsigned PPROD_W   = CHARGE_W + STRIP_BITS;
  localparam int unsigned TPROD_W   = CHARGE_W + TIME_W;
  localparam int unsigned PSUM_W    = PPROD_W + CNT_W;
  localparam int unsigned TSUM_W    = TPROD_W + CNT_W;
  localparam int unsigned POS_STEPS = STRIP_BITS + FRAC_BITS;
  localparam int unsigned TIM_STEPS = CTIME_W;
  localparam int unsigned QuotW     = (POS_STEPS > TIM_STEPS) ? POS_STEPS : TIM_STEPS;

  shc_state_e state_q, state_d;

  // Configuration
  logic [CHARGE_W-1:0] thr_q;

  // Latched hit
  logic [STRIP_BITS-1:0] strip_q;
  logic [CHARGE_W-1:0]   chg_in_q;
  logic [TIME_W-1:0]     tim_in_q;
  logic                  last_q;

  // Open cluster accumulators
  logic                  open_q, open_d;
  logic [STRIP_BITS-1:0] prev_q, prev_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [SUM_W-1:0]      charge_q, charge_d;
  logic [PSUM_W-1:0]     psum_q, psum_d;
  logic [TSUM_W-1:0]     tsum_q, tsum_d;
  logic                  over_q, over_d;

  // Sequencing flags
  logic emit_last_q, emit_last_d;
  logic upd_done_q, upd_done_d;

  // Position quotient waiting for the time quotient
  logic [POS_W-1:0] pos_q;

  // Output register
  logic               ovalid_q;
  logic [SIZE_W-1:0]  osize_q;
  logic [SUM_W-1:0]   ocharge_q;
  logic [POS_W-1:0]   opos_q;
  logic [CTIME_W-1:0] otime_q;
  logic               oover_q;
  logic               olast_q;

  logic               hit_take;
  logic               counting;
  logic               adjacent;
  logic               out_free;
  logic               push_load;
  logic [PPROD_W-1:0] pprod;
  logic [TPROD_W-1:0] tprod;
  logic [SUM_W:0]     csum;
  logic [POS_W-1:0]   pos_clamp;
  logic [CTIME_W-1:0] time_clamp;

  shc_div_req_t     div_req;
  logic [QuotW-1:0] div_num;
  logic             div_done;
  logic [QuotW-1:0] div_quot;

  // Hit classification
  assign hit_take  = hit_i.valid && hit_i.ready;
  assign counting  = (chg_in_q > thr_q);
  assign adjacent  = open_q && ({1'b0, strip_q} == ({1'b0, prev_q} + (STRIP_BITS+1)'(1)));
  assign out_free  = !ovalid_q || cluster_o.ready;
  assign push_load = (state_q == ST_PUSH) && out_free;

  // Weight products
  assign pprod = PPROD_W'(chg_in_q) * PPROD_W'(strip_q);
  assign tprod = TPROD_W'(chg_in_q) * TPROD_W'(tim_in_q);
  assign csum  = {1'b0, charge_q} + (SUM_W+1)'(chg_in_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (hit_take) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        priority if (counting && (adjacent || !open_q)) state_d = ST_UPDATE;
        else if (open_q)                                 state_d = ST_POS_GO;
        else                                             state_d = ST_IDLE;
      end
      ST_POS_GO: state_d = ST_POS_WAIT;
      ST_POS_WAIT: begin
        if (div_done) state_d = ST_TIM_GO;
      end
      ST_TIM_GO: state_d = ST_TIM_WAIT;
      ST_TIM_WAIT: begin
        if (div_done) state_d = ST_PUSH;
      end
      ST_PUSH: begin
        if (out_free) state_d = (counting && !upd_done_q) ? ST_UPDATE : ST_IDLE;
      end
      ST_UPDATE: state_d = last_q ? ST_POS_GO : ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Handshake and divider requests
  always_comb begin
    hit_i.ready     = (state_q == ST_IDLE);
    cfg_i.ready     = 1'b1;
    div_req.start   = (state_q == ST_POS_GO) || (state_q == ST_TIM_GO);
    div_req.divisor = charge_q;
    if (state_q == ST_POS_GO) begin
      div_req.steps    = DIV_STEP_W'(POS_STEPS);
      div_req.rem_init = SUM_W'(psum_q >> STRIP_BITS);
      div_num = QuotW'({psum_q[STRIP_BITS-1:0], {FRAC_BITS{1'b0}}}) << (QuotW - POS_STEPS);
    end else begin
      div_req.steps    = DIV_STEP_W'(TIM_STEPS);
      div_req.rem_init = SUM_W'(tsum_q >> FRAC_BITS);
      div_num = QuotW'({tsum_q[FRAC_BITS-1:0], {FRAC_BITS{1'b0}}}) << (QuotW - TIM_STEPS);
    end
  end

  // Flags
  always_comb begin
    emit_last_d = emit_last_q;
    upd_done_d  = upd_done_q;
    if (hit_take) upd_done_d = 1'b0;
    if (state_q == ST_CHECK) emit_last_d = !counting && last_q;
    if (state_q == ST_UPDATE) begin
      upd_done_d  = 1'b1;
      emit_last_d = 1'b1;
    end
  end

  // Accumulator update
  always_comb begin
    open_d   = open_q;
    prev_d   = prev_q;
    count_d  = count_q;
    charge_d = charge_q;
    psum_d   = psum_q;
    tsum_d   = tsum_q;
    over_d   = over_q;
    if (push_load) begin
      open_d   = 1'b0;
      count_d  = '0;
      charge_d = '0;
      psum_d   = '0;
      tsum_d   = '0;
      over_d   = 1'b0;
    end else if (state_q == ST_UPDATE) begin
      prev_d = strip_q;
      if (adjacent) begin
        if (32'(count_q) >= MAX_CLUSTER) begin
          over_d = 1'b1;
        end else begin
          count_d  = count_q + CNT_W'(1);
          charge_d = csum[SUM_W] ? {SUM_W{1'b1}} : csum[SUM_W-1:0];
          psum_d   = psum_q + PSUM_W'(pprod);
          tsum_d   = tsum_q + TSUM_W'(tprod);
        end
      end else begin
        open_d   = 1'b1;
        count_d  = CNT_W'(1);
        charge_d = SUM_W'(chg_in_q);
        psum_d   = PSUM_W'(pprod);
        tsum_d   = TSUM_W'(tprod);
        over_d   = 1'b0;
      end
    end
  end

  // Quotient clamps
  assign pos_clamp  = (32'(div_quot) > POS_SAT) ? POS_W'(POS_SAT) : POS_W'(div_quot);
  assign time_clamp = (32'(div_quot) > CTIME_SAT) ? CTIME_W'(CTIME_SAT) : CTIME_W'(div_quot);

  // Control and accumulator registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= '0;
      open_q      <= 1'b0;
      prev_q      <= '0;
      count_q     <= '0;
      charge_q    <= '0;
      psum_q      <= '0;
      tsum_q      <= '0;
      over_q      <= 1'b0;
      emit_last_q <= 1'b0;
      upd_done_q  <= 1'b0;
      ovalid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      open_q      <= open_d;
      prev_q      <= prev_d;
      count_q     <= count_d;
      charge_q    <= charge_d;
      psum_q      <= psum_d;
      tsum_q      <= tsum_d;
      over_q      <= over_d;
      emit_last_q <= emit_last_d;
      upd_done_q  <= upd_done_d;
      if (cfg_i.valid) thr_q <= cfg_i.charge_threshold;
      if (push_load) ovalid_q <= 1'b1;
      else if (cluster_o.ready) ovalid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (hit_take) begin
      strip_q  <= STRIP_BITS'(hit_i.strip_number);
      chg_in_q <= hit_i.strip_charge;
      tim_in_q <= hit_i.strip_time;
      last_q   <= hit_i.last_strip;
    end
    if ((state_q == ST_POS_WAIT) && div_done) pos_q <= pos_clamp;
    if (push_load) begin
      osize_q   <= (32'(count_q) > SIZE_SAT) ? SIZE_W'(SIZE_SAT) : SIZE_W'(count_q);
      ocharge_q <= charge_q;
      // empty charge sum gives a zero centroid
      opos_q    <= (charge_q == '0) ? '0 : pos_q;
      otime_q   <= (charge_q == '0) ? '0 : time_clamp;
      oover_q   <= over_q;
      olast_q   <= emit_last_q;
    end
  end

  assign cluster_o.valid            = ovalid_q;
  assign cluster_o.cluster_size     = osize_q;
  assign cluster_o.cluster_charge   = ocharge_q;
  assign cluster_o.cluster_position = opos_q;
  assign cluster_o.cluster_time     = otime_q;
  assign cluster_o.oversize         = oover_q;
  assign cluster_o.last_of_board    = olast_q;

  // Shared divider
  shc_div #(
    .QuotW (QuotW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (div_num),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  `SHC_ASSERT_IMP(a_done_in_wait, div_done, (state_q == ST_POS_WAIT) || (state_q == ST_TIM_WAIT), "divider done outside wait")
  `SHC_ASSERT_IMP(a_count_range, open_q, (count_q != '0) && (32'(count_q) <= MAX_CLUSTER), "strip count out of range")
  `SHC_ASSERT_IMP(a_closed_empty, !open_q, (count_q == '0) && (charge_q == '0) && !over_q, "closed cluster not cleared")
  `SHC_ASSERT_NXT(a_push_valid, push_load, ovalid_q, "pushed word not presented")

endmodule
